// ----- sv/stmr_pkg.sv -----
// shared types, constants and sequencer states for the servo timed move ramp
package stmr_pkg;

	localparam int NUM_SERVOS = 8;
	localparam int CH_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int REPORT_MAX = 8;
	localparam int REPORT_N = (NUM_SERVOS < REPORT_MAX) ? NUM_SERVOS : REPORT_MAX;

	localparam int OUT_CH_W = 3;
	localparam int PULSE_W = 12;
	localparam int STEP_W = 11;
	localparam int MAG_W = 11;
	localparam int TIME_W = 15;
	localparam int PROD_W = MAG_W + STEP_W;
	localparam int DIV_CNT_W = $clog2(MAG_W);
	localparam int RECIP_W = 16;
	localparam int RECIP_PROD_W = TIME_W + RECIP_W;

	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [15:0] PULSE_MIN = 16'd500;
	localparam logic [15:0] PULSE_MAX = 16'd2500;
	localparam logic [15:0] PULSE_LIMIT_LO = 16'd900;
	localparam logic [15:0] PULSE_LIMIT_HI = 16'd2200;
	localparam logic [15:0] TIME_MIN = 16'd20;
	localparam logic [15:0] TIME_MAX = 16'd30000;
	localparam logic [7:0] WIDE_CHANNEL = 8'd6;
	localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd1500;
	localparam logic [TIME_W-1:0] TIME_RESET = 15'd2000;

	// floor(t / 20) as (t * 52429) >> 20, exact for t up to 30000
	localparam logic [RECIP_W-1:0] STEP_RECIP = 16'd52429;
	localparam int STEP_SHIFT = 20;

	typedef struct packed {
		logic cmd;
		logic [7:0] channel;
		logic [15:0] pulse;
		logic [15:0] move_time;
	} req_t;

	typedef struct packed {
		logic [OUT_CH_W-1:0] out_channel;
		logic [PULSE_W-1:0] position;
		logic accepted;
		logic moving;
		logic last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LATCH,
		ST_STEP,
		ST_CHAN,
		ST_DIV,
		ST_WB,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/servo_timed_move_ramp_core.sv -----
// servo timed move ramp: eight-channel linear interpolation with a shared serial divider
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (req_t)
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)
//
// set request: one result
// tick: a step state, then chan and emit per channel, with divide and write-back between them on a ramp tick
// a tick that latches a pending change goes through the latch state first
// the per-channel ramp position comes from the restoring divider, one quotient bit per cycle
// arst_n clears positions and targets to 1500 and stored time to 2000
// rsp_stall holds the result register and the sequencer in emit; req_stall is high while a request is worked
module servo_timed_move_ramp_core
	import stmr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	state_t state_q, state_d;

	logic [PULSE_W-1:0] cur_q [NUM_SERVOS];
	logic [PULSE_W-1:0] tgt_q [NUM_SERVOS];
	logic signed [PULSE_W-1:0] diff_q [NUM_SERVOS];
	logic [STEP_W-1:0] total_q, left_q;
	logic [TIME_W-1:0] time_q;
	logic pending_q, running_q;

	logic [CH_W-1:0] idx_q;
	logic tick_q, latch_q, finish_q, ramp_q;
	logic neg_q;
	logic [STEP_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	rsp_t set_rsp_q, rsp_q;
	logic rsp_valid_q;

	logic req_fire, set_ok, out_free, report, idx_last, rsp_load;
	logic [CH_W-1:0] req_ch, rd_addr;
	logic [15:0] t_clamp, p_clamp;
	logic [PULSE_W-1:0] cur_rd, tgt_rd, mag_full, wb_val, part;
	logic signed [PULSE_W-1:0] d_now;
	logic [PROD_W-1:0] prod;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [STEP_W-1:0] steps_calc;
	logic [STEP_W:0] shifted, rem_sub;
	logic div_ge;
	logic step_fin;
	rsp_t emit_rsp;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire = req_valid && (state_q == ST_IDLE);
	assign req_ch = req.channel[CH_W-1:0];

	assign set_ok = (req.channel < 8'(NUM_SERVOS)) && (req.pulse >= PULSE_MIN)
		&& (req.pulse <= PULSE_MAX);

	always_comb begin
		t_clamp = req.move_time;
		if (t_clamp < TIME_MIN) begin
			t_clamp = TIME_MIN;
		end
		if (t_clamp > TIME_MAX) begin
			t_clamp = TIME_MAX;
		end
		p_clamp = req.pulse;
		if (req.channel != WIDE_CHANNEL) begin
			if (p_clamp > PULSE_LIMIT_HI) begin
				p_clamp = PULSE_LIMIT_HI;
			end
			if (p_clamp < PULSE_LIMIT_LO) begin
				p_clamp = PULSE_LIMIT_LO;
			end
		end
	end

	assign rd_addr = (state_q == ST_IDLE) ? req_ch : idx_q;
	assign cur_rd = cur_q[rd_addr];
	assign tgt_rd = tgt_q[idx_q];

	assign d_now = latch_q ? $signed(cur_rd - tgt_rd) : diff_q[idx_q];
	assign mag_full = d_now[PULSE_W-1] ? PULSE_W'(-d_now) : PULSE_W'(d_now);
	assign prod = PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(left_q);

	assign recip_prod = RECIP_PROD_W'(time_q) * RECIP_PROD_W'(STEP_RECIP);
	assign steps_calc = recip_prod[STEP_SHIFT +: STEP_W];

	assign step_fin = (left_q <= STEP_W'(1)) || (total_q == '0);

	// restoring division step
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign div_ge = (shifted >= {1'b0, total_q});
	assign rem_sub = shifted - {1'b0, total_q};

	assign part = neg_q ? PULSE_W'(-{1'b0, quo_q}) : PULSE_W'(quo_q);
	assign wb_val = tgt_rd + part;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign report = !tick_q || (32'(idx_q) < REPORT_N);
	assign idx_last = (32'(idx_q) == NUM_SERVOS - 1);

	always_comb begin
		if (tick_q) begin
			emit_rsp.out_channel = OUT_CH_W'(idx_q);
			emit_rsp.position = cur_rd;
			emit_rsp.accepted = 1'b1;
			emit_rsp.moving = running_q;
			emit_rsp.last = (32'(idx_q) == REPORT_N - 1);
		end else begin
			emit_rsp = set_rsp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.cmd == CMD_TICK) begin
						state_d = pending_q ? ST_LATCH : ST_STEP;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_LATCH: state_d = ST_STEP;
			ST_STEP: state_d = ST_CHAN;
			ST_CHAN: state_d = ramp_q ? ST_DIV : ST_EMIT;
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
					state_d = ST_WB;
				end
			end
			ST_WB: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!report || out_free) begin
					rsp_load = report;
					state_d = (!tick_q || idx_last) ? ST_IDLE : ST_CHAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				cur_q[i] <= PULSE_RESET;
				tgt_q[i] <= PULSE_RESET;
				diff_q[i] <= '0;
			end
			total_q <= '0;
			left_q <= '0;
			time_q <= TIME_RESET;
			pending_q <= 1'b0;
			running_q <= 1'b0;
			idx_q <= '0;
			tick_q <= 1'b0;
			latch_q <= 1'b0;
			finish_q <= 1'b0;
			ramp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						tick_q <= (req.cmd == CMD_TICK);
						latch_q <= (req.cmd == CMD_TICK) && pending_q;
						idx_q <= '0;
						if (req.cmd == CMD_SET && set_ok) begin
							tgt_q[req_ch] <= PULSE_W'(p_clamp);
							time_q <= TIME_W'(t_clamp);
							pending_q <= 1'b1;
						end
					end
				end
				ST_LATCH: begin
					pending_q <= 1'b0;
					total_q <= steps_calc;
					left_q <= steps_calc;
					running_q <= 1'b1;
				end
				ST_STEP: begin
					if (running_q) begin
						left_q <= step_fin ? '0 : left_q - STEP_W'(1);
						running_q <= !step_fin;
						finish_q <= step_fin;
						ramp_q <= !step_fin;
					end else begin
						finish_q <= 1'b0;
						ramp_q <= 1'b0;
					end
				end
				ST_CHAN: begin
					if (latch_q) begin
						diff_q[idx_q] <= d_now;
					end
					if (finish_q) begin
						cur_q[idx_q] <= tgt_rd;
					end
					cnt_q <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
				ST_WB: begin
					cur_q[idx_q] <= wb_val;
				end
				ST_EMIT: begin
					if ((!report || out_free) && tick_q && !idx_last) begin
						idx_q <= idx_q + CH_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req.cmd == CMD_SET) begin
			if (set_ok) begin
				set_rsp_q.out_channel <= OUT_CH_W'(req_ch);
				set_rsp_q.position <= cur_rd;
				set_rsp_q.accepted <= 1'b1;
			end else begin
				set_rsp_q.out_channel <= '0;
				set_rsp_q.position <= '0;
				set_rsp_q.accepted <= 1'b0;
			end
			set_rsp_q.moving <= running_q;
			set_rsp_q.last <= 1'b1;
		end
		if (state_q == ST_CHAN && ramp_q) begin
			neg_q <= d_now[PULSE_W-1];
			rem_q <= prod[PROD_W-1 -: STEP_W];
			quo_q <= prod[MAG_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= div_ge ? rem_sub[STEP_W-1:0] : shifted[STEP_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], div_ge};
		end
		if (rsp_load) begin
			rsp_q <= emit_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_running_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (total_q != '0))
		else $error("move running with zero step count");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (left_q == '0))
		else $error("step count left over after move end");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < total_q))
		else $error("divider remainder not below divisor");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_EMIT))
		else $error("result loaded outside emit state");

endmodule

// ----- tb/sv/servo_timed_move_ramp_core_tb.sv -----
// self-checking testbench for the servo timed move ramp core
module servo_timed_move_ramp_core_tb
	import stmr_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICK_MS = 20;
	localparam int RANDOM_ITEMS = 435;
	localparam int HOLD_CYCLES = 1500;
	localparam int HOLD_AFTER = 120;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_mode_t;

	typedef struct packed {
		req_t r;
		logic pinned;
		rsp_t exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic pinned_on = 1'b0;
	rsp_t pinned_rsp = '0;

	int cur_pos[NUM_SERVOS];
	int tgt_pos[NUM_SERVOS];
	int ramp_diff[NUM_SERVOS];
	int ramp_total;
	int ramp_left;
	int move_ms;
	logic change_armed;
	logic ramp_on;

	rsp_t ramp_expect[$];
	stim_row_t stim[$];
	int req_count = 0;
	int fail_count = 0;
	int idle_cycles = 0;

	servo_timed_move_ramp_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_ramp(input req_t r);
		int p;
		int t;
		int ch;
		rsp_t o;
		p = int'(r.pulse);
		t = int'(r.move_time);
		ch = int'(r.channel);
		o = '0;
		if (r.cmd == CMD_SET) begin
			o.moving = ramp_on;
			o.last = 1'b1;
			if (ch < NUM_SERVOS && p >= PULSE_MIN && p <= PULSE_MAX) begin
				if (t < TIME_MIN) t = int'(TIME_MIN);
				if (t > TIME_MAX) t = int'(TIME_MAX);
				if (ch != WIDE_CHANNEL) begin
					if (p > PULSE_LIMIT_HI) p = int'(PULSE_LIMIT_HI);
					if (p < PULSE_LIMIT_LO) p = int'(PULSE_LIMIT_LO);
				end
				tgt_pos[ch] = p;
				move_ms = t;
				change_armed = 1'b1;
				o.out_channel = ch[OUT_CH_W-1:0];
				o.position = cur_pos[ch][PULSE_W-1:0];
				o.accepted = 1'b1;
			end
			ramp_expect.push_back(o);
		end else begin
			if (change_armed) begin
				change_armed = 1'b0;
				ramp_total = move_ms / TICK_MS;
				ramp_left = ramp_total;
				for (int i = 0; i < NUM_SERVOS; i++)
					ramp_diff[i] = cur_pos[i] - tgt_pos[i];
				ramp_on = 1'b1;
			end
			if (ramp_on) begin
				if (ramp_left > 0) ramp_left--;
				if (ramp_left == 0 || ramp_total == 0) begin
					ramp_left = 0;
					for (int i = 0; i < NUM_SERVOS; i++)
						cur_pos[i] = tgt_pos[i];
					ramp_on = 1'b0;
				end else begin
					for (int i = 0; i < NUM_SERVOS; i++)
						cur_pos[i] = tgt_pos[i] + (ramp_diff[i] * ramp_left) / ramp_total;
				end
			end
			for (int i = 0; i < REPORT_N; i++) begin
				o.out_channel = i[OUT_CH_W-1:0];
				o.position = cur_pos[i][PULSE_W-1:0];
				o.accepted = 1'b1;
				o.moving = ramp_on;
				o.last = (i == REPORT_N - 1);
				ramp_expect.push_back(o);
			end
		end
	endfunction

	function automatic stim_row_t mk_row(input logic cmd, input int ch, input int pulse,
			input int ms, input logic pinned, input int exp_ch, input int exp_pos,
			input logic exp_acc);
		stim_row_t row;
		row.r.cmd = cmd;
		row.r.channel = ch[7:0];
		row.r.pulse = pulse[15:0];
		row.r.move_time = ms[15:0];
		row.pinned = pinned;
		row.exp.out_channel = exp_ch[OUT_CH_W-1:0];
		row.exp.position = exp_pos[PULSE_W-1:0];
		row.exp.accepted = exp_acc;
		row.exp.moving = 1'b0;
		row.exp.last = 1'b1;
		return row;
	endfunction

	initial begin
		for (int i = 0; i < NUM_SERVOS; i++) begin
			cur_pos[i] = int'(PULSE_RESET);
			tgt_pos[i] = int'(PULSE_RESET);
			ramp_diff[i] = 0;
		end
		ramp_total = 0;
		ramp_left = 0;
		move_ms = int'(TIME_RESET);
		change_armed = 1'b0;
		ramp_on = 1'b0;
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_ramp(req);
				if (pinned_on) begin
					void'(ramp_expect.pop_back());
					ramp_expect.push_back(pinned_rsp);
				end
				req_count++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (ramp_expect.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: unexpected result ch %0d pos %0d acc %b mov %b last %b",
							$realtime, rsp.out_channel, rsp.position, rsp.accepted,
							rsp.moving, rsp.last);
					fail_count++;
				end else begin
					want = ramp_expect.pop_front();
					if (rsp.out_channel !== want.out_channel || rsp.position !== want.position
							|| rsp.accepted !== want.accepted || rsp.moving !== want.moving
							|| rsp.last !== want.last) begin
						if (fail_count < REPORT_LIMIT)
							$display({"%0t: mismatch exp ch %0d pos %0d acc %b mov %b last %b,",
								" got ch %0d pos %0d acc %b mov %b last %b"}, $realtime,
								want.out_channel, want.position, want.accepted, want.moving,
								want.last, rsp.out_channel, rsp.position, rsp.accepted,
								rsp.moving, rsp.last);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("servo_timed_move_ramp_core regression: fail");
					$finish;
				end
			end
		end
	end

	// receiver: stall segments of varying shape, one long hold-off to back up the block
	initial begin : receiver
		stall_mode_t mode;
		int seg;
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && req_count >= HOLD_AFTER) begin
				held = 1'b1;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
				end
			end
			mode = stall_mode_t'($urandom_range(0, 2));
			seg = $urandom_range(20, 200);
			for (int k = 0; k < seg; k++) begin
				@(negedge clk);
				case (mode)
					STALL_NONE: rsp_stall <= 1'b0;
					STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
					default: rsp_stall <= ((k % 5) < 2);
				endcase
			end
		end
	end

	initial begin : sender
		req_t r;
		stim_row_t row;
		int sel;
		int idx;
		int burst;
		int seen;

		stim.push_back(mk_row(CMD_SET, 0, PULSE_MAX, 0, 1'b1, 0, PULSE_RESET, 1'b1));
		stim.push_back(mk_row(CMD_SET, NUM_SERVOS, 1500, 100, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 255, 1500, 100, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 0, PULSE_MIN - 1, 100, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 1, PULSE_MAX + 1, 100, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 2, 65535, 65535, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 3, 0, 0, 1'b1, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, WIDE_CHANNEL, PULSE_MIN, 65535, 1'b1,
			WIDE_CHANNEL, PULSE_RESET, 1'b1));
		stim.push_back(mk_row(CMD_SET, 7, PULSE_MIN, 19, 1'b1, 7, PULSE_RESET, 1'b1));
		stim.push_back(mk_row(CMD_TICK, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_TICK, 255, 65535, 65535, 1'b0, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, WIDE_CHANNEL, PULSE_MAX, 100, 1'b0, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 0, PULSE_LIMIT_LO, 100, 1'b0, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 1, PULSE_LIMIT_HI, 100, 1'b0, 0, 0, 1'b0));
		repeat (3) stim.push_back(mk_row(CMD_TICK, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		// set while moving restarts from present positions
		stim.push_back(mk_row(CMD_SET, 3, 2000, 60, 1'b0, 0, 0, 1'b0));
		repeat (4) stim.push_back(mk_row(CMD_TICK, 0, 0, 0, 1'b0, 0, 0, 1'b0));
		stim.push_back(mk_row(CMD_SET, 5, 1234, TIME_MAX + 1, 1'b0, 0, 0, 1'b0));
		repeat (2) stim.push_back(mk_row(CMD_TICK, 0, 0, 0, 1'b0, 0, 0, 1'b0));

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			sel = $urandom_range(0, 99);
			r.channel = 8'($urandom);
			r.pulse = 16'($urandom);
			r.move_time = 16'($urandom);
			if (sel < 55) begin
				r.cmd = CMD_TICK;
			end else begin
				r.cmd = CMD_SET;
				if (sel < 90) begin
					r.channel = 8'($urandom_range(0, NUM_SERVOS - 1));
					r.pulse = 16'($urandom_range(PULSE_MIN, PULSE_MAX));
					if ($urandom_range(0, 9) != 0)
						r.move_time = 16'($urandom_range(0, 300));
				end
			end
			row.r = r;
			row.pinned = 1'b0;
			row.exp = '0;
			stim.push_back(row);
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idx = 0;
		while (idx < stim.size()) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && idx < stim.size()) begin
				req <= stim[idx].r;
				pinned_on <= stim[idx].pinned;
				pinned_rsp <= stim[idx].exp;
				req_valid <= 1'b1;
				seen = req_count;
				do @(negedge clk); while (req_count == seen);
				idx++;
				burst--;
			end
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
		req_valid <= 1'b0;

		while (ramp_expect.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && ramp_expect.size() == 0)
			$display("servo_timed_move_ramp_core regression: pass");
		else
			$display("servo_timed_move_ramp_core regression: fail");
		$finish;
	end

endmodule
